>>> rtl/rm_pkg.sv
// ----------------------------------------------------------------------------
// rm_pkg
// Shared constants, types and state codes of the running median block.
// ----------------------------------------------------------------------------
package rm_pkg;

  // Default store depth and sample width.
  localparam int RM_MAX_SAMPLES = 1024;
  localparam int RM_SAMPLE_BITS = 16;

  // Width of one first-level group of the median select tree.
  localparam int RM_GROUP = 32;

  // Control bits that one cell hands to its upper neighbor.
  typedef struct packed {
    logic valid;  // the cell holds a stored sample
    logic gt;     // the stored sample is greater than the incoming word
    logic mk;     // the cell sits at the upper middle position
  } cell_ctl_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GRP  = 4'b0010,
    S_TOP  = 4'b0100,
    S_DONE = 4'b1000
  } rm_state_t;

endpackage

>>> rtl/running_median.sv
// ----------------------------------------------------------------------------
// running_median
// Streaming median of signed samples over a sorted insertion chain of cells.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Ports
// -------  ---------  -----------------------------------------------------
// in       input      in_valid, in_stall, in_sample
// out      output     out_valid, out_stall, out_median_doubled,
//                     out_sample_count, out_overflow
//
// For each word, the accepting edge inserts the sample into the chain, then
// the two registered levels of the median select tree load in turn, and the
// doubled median is formed into the output register. A new word is taken
// while the previous result still waits in the output register; the sequencer
// only waits in its last state if that register is still full and out_stall
// is high. Reset is synchronous and active low; it empties the chain and
// puts the middle marker on the first cell. No clearing pass is needed.
//
module running_median #(
  parameter int MAX_SAMPLES = rm_pkg::RM_MAX_SAMPLES,
  parameter int SAMPLE_BITS = rm_pkg::RM_SAMPLE_BITS,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS:0]   out_median_doubled,
  output logic [CNT_W-1:0]              out_sample_count,
  output logic                          out_overflow
);
  import rm_pkg::*;

  localparam int NGRP = (MAX_SAMPLES + RM_GROUP - 1) / RM_GROUP;

  // Sequencer and bookkeeping.
  rm_state_t               state_r;
  rm_state_t               state_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    rej_r;
  logic                    in_acc;
  logic                    full;
  logic                    ins;
  logic                    mk_shift;
  logic                    odd;
  logic                    out_load;

  // Output register.
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [SAMPLE_BITS:0] med_r;
  logic [CNT_W-1:0]        cnt_out_r;
  logic                    ovf_r;
  logic signed [SAMPLE_BITS:0] med_nxt;

  // Chain of cells.
  logic signed [SAMPLE_BITS-1:0] cell_val [MAX_SAMPLES];
  cell_ctl_t                     cell_ctl [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0]        mk_vec;

  // Select tree.
  logic [SAMPLE_BITS-1:0] hi_gate [NGRP][RM_GROUP];
  logic [SAMPLE_BITS-1:0] lo_gate [NGRP][RM_GROUP];
  logic [SAMPLE_BITS-1:0] hi_grp  [NGRP];
  logic [SAMPLE_BITS-1:0] lo_grp  [NGRP];
  logic [SAMPLE_BITS-1:0] hi_top_r;
  logic [SAMPLE_BITS-1:0] lo_top_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(MAX_SAMPLES));
  assign ins      = in_acc && !full;
  assign odd      = count_r[0];

  // The upper middle index is count/2; it moves up by one whenever the count
  // goes from odd to even.
  assign mk_shift = ins && odd;

  assign count_nxt = ins ? count_r + CNT_W'(1) : count_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_GRP;
        end
      end
      S_GRP:  state_nxt = S_TOP;
      S_TOP:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rej_r <= full;
    end
  end

  // The sorted chain. The lowest cell sees a valid, never-greater neighbor
  // below it, so it takes the new word whenever it is empty or greater.
  genvar k;
  generate
    for (k = 0; k < MAX_SAMPLES; k++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] pv;
      cell_ctl_t                     pc;
      if (k == 0) begin : g_first
        assign pv = '0;
        assign pc = '{valid: 1'b1, gt: 1'b0, mk: 1'b0};
      end else begin : g_rest
        assign pv = cell_val[k-1];
        assign pc = cell_ctl[k-1];
      end
      rm_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FIRST       (k == 0)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ins      (ins),
        .mk_shift (mk_shift),
        .x        (in_sample),
        .prev_val (pv),
        .prev_ctl (pc),
        .val_r    (cell_val[k]),
        .ctl      (cell_ctl[k])
      );
      assign mk_vec[k] = cell_ctl[k].mk;
    end
  endgenerate

  // Gate each cell onto the select tree. The upper middle is the marked cell.
  // The lower middle is the same cell for an odd count, else the cell just
  // below the marker.
  genvar g, j;
  generate
    for (g = 0; g < NGRP; g++) begin : g_grp
      for (j = 0; j < RM_GROUP; j++) begin : g_slot
        localparam int IDX = g * RM_GROUP + j;
        if (IDX < MAX_SAMPLES - 1) begin : g_mid
          assign hi_gate[g][j] = mk_vec[IDX] ? cell_val[IDX] : '0;
          assign lo_gate[g][j] = (odd ? mk_vec[IDX] : mk_vec[IDX+1]) ? cell_val[IDX] : '0;
        end else if (IDX < MAX_SAMPLES) begin : g_last
          assign hi_gate[g][j] = mk_vec[IDX] ? cell_val[IDX] : '0;
          assign lo_gate[g][j] = (odd && mk_vec[IDX]) ? cell_val[IDX] : '0;
        end else begin : g_pad
          assign hi_gate[g][j] = '0;
          assign lo_gate[g][j] = '0;
        end
      end
      rm_or_stage #(.WIDTH(SAMPLE_BITS), .NUM(RM_GROUP)) u_hi1 (
        .clk    (clk),
        .ld     (state_r == S_GRP),
        .din    (hi_gate[g]),
        .dout_r (hi_grp[g])
      );
      rm_or_stage #(.WIDTH(SAMPLE_BITS), .NUM(RM_GROUP)) u_lo1 (
        .clk    (clk),
        .ld     (state_r == S_GRP),
        .din    (lo_gate[g]),
        .dout_r (lo_grp[g])
      );
    end
  endgenerate

  rm_or_stage #(.WIDTH(SAMPLE_BITS), .NUM(NGRP)) u_hi2 (
    .clk    (clk),
    .ld     (state_r == S_TOP),
    .din    (hi_grp),
    .dout_r (hi_top_r)
  );

  rm_or_stage #(.WIDTH(SAMPLE_BITS), .NUM(NGRP)) u_lo2 (
    .clk    (clk),
    .ld     (state_r == S_TOP),
    .din    (lo_grp),
    .dout_r (lo_top_r)
  );

  // Sum of the two middle words, both sign-extended by one bit. For an odd
  // count both selects hit the same cell, which doubles it.
  assign med_nxt = $signed({hi_top_r[SAMPLE_BITS-1], hi_top_r})
                 + $signed({lo_top_r[SAMPLE_BITS-1], lo_top_r});

  assign out_load      = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (out_load) begin
      med_r     <= med_nxt;
      cnt_out_r <= count_r;
      ovf_r     <= rej_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = med_r;
  assign out_sample_count   = cnt_out_r;
  assign out_overflow       = ovf_r;

`ifndef SYNTHESIS
  // An accepted word always starts the select sequence.
  a_acc_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_GRP)
    else $error("accepted word did not start the select sequence");

  // The store never holds more than its depth.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SAMPLES))
    else $error("stored count above store depth");

  // Exactly one cell carries the middle marker.
  a_mk_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(mk_vec))
    else $error("middle marker is not one-hot");

  // A rejected word leaves the count unchanged.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full) |=> $stable(count_r))
    else $error("count changed on a rejected word");

  // An empty output register is filled as soon as the result is ready.
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished result was not loaded into an empty output register");
`endif

endmodule

>>> rtl/rm_cell.sv
// ----------------------------------------------------------------------------
// rm_cell
// One slot of the sorted insertion chain, with its middle-position marker.
// ----------------------------------------------------------------------------
module rm_cell #(
  parameter int SAMPLE_BITS = rm_pkg::RM_SAMPLE_BITS,
  parameter bit FIRST       = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ins,
  input  logic                          mk_shift,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] prev_val,
  input  rm_pkg::cell_ctl_t             prev_ctl,
  output logic signed [SAMPLE_BITS-1:0] val_r,
  output rm_pkg::cell_ctl_t             ctl
);
  import rm_pkg::*;

  logic                          valid_r;
  logic                          valid_nxt;
  logic                          mk_r;
  logic                          mk_nxt;
  logic                          gt;
  logic signed [SAMPLE_BITS-1:0] val_nxt;

  assign gt = valid_r && (val_r > x);

  // A greater neighbor below shifts up into this slot; the first slot that
  // is greater or empty takes the new word.
  always_comb begin
    val_nxt = val_r;
    if (ins) begin
      if (prev_ctl.gt) begin
        val_nxt = prev_val;
      end else if (gt || !valid_r) begin
        val_nxt = x;
      end
    end
  end

  assign valid_nxt = ins ? (valid_r | prev_ctl.valid) : valid_r;
  assign mk_nxt    = mk_shift ? prev_ctl.mk : mk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mk_r    <= FIRST;
    end else begin
      valid_r <= valid_nxt;
      mk_r    <= mk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign ctl.valid = valid_r;
  assign ctl.gt    = gt;
  assign ctl.mk    = mk_r;

endmodule

>>> rtl/rm_or_stage.sv
// ----------------------------------------------------------------------------
// rm_or_stage
// One registered level of the median select tree: ORs pre-gated words.
// ----------------------------------------------------------------------------
module rm_or_stage #(
  parameter int WIDTH = rm_pkg::RM_SAMPLE_BITS,
  parameter int NUM   = rm_pkg::RM_GROUP
) (
  input  logic             clk,
  input  logic             ld,
  input  logic [WIDTH-1:0] din [NUM],
  output logic [WIDTH-1:0] dout_r
);
  import rm_pkg::*;

  logic [WIDTH-1:0] acc;

  // At most one input is nonzero, so the OR is a select.
  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM; i++) begin
      acc = acc | din[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      dout_r <= acc;
    end
  end

endmodule
